[rtl/psrs_pkg.sv]
// Package for the paged serial register slave: sizes, command word and result types.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package psrs_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int REG_BYTES   = 3;
    localparam int PAGE_BITS   = 6;
    localparam int ADDR_W      = 12;
    localparam int VALUE_W     = 24;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int STORE_DEPTH = NUM_PAGES * 64;
    localparam int MEM_AW      = $clog2(STORE_DEPTH);
    localparam int PEND_W      = $clog2(REG_BYTES + 1);
    localparam int IDX_W       = 2;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // Result kinds on o_kind
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSTR = 2'd2;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_INSTR
    } t_cmd;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_W-1:0]    addr;
        logic [VALUE_W-1:0]   data;
        logic [PAGE_BITS-1:0] code;
    } t_cmd_word;

    typedef struct packed {
        logic                 strobe;
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    tx_byte;
        logic                 last;
        logic [ADDR_W-1:0]    reg_address;
        logic [VALUE_W-1:0]   reg_value;
        logic [PAGE_BITS-1:0] instr_code;
    } t_result;

    // Byte idx of a register value, least significant first; bytes past the width read 0.
    function automatic logic [BYTE_W-1:0] byte_of(input logic [VALUE_W-1:0] v,
                                                  input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = v[7:0];
            2'd1:    b = v[15:8];
            2'd2:    b = v[23:16];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

[rtl/psrs_front.sv]
// Front end of the paged serial register slave: decodes received bytes, tracks the page,
// gathers write data and queues read, write and instruction words. Uses psrs_pkg.
module psrs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [psrs_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_push,
    output psrs_pkg::t_cmd_word         o_word
);

    typedef enum logic [1:0] {
        TOP_READ  = 2'b00,
        TOP_WRITE = 2'b01,
        TOP_PAGE  = 2'b10,
        TOP_INSTR = 2'b11
    } t_top;

    localparam logic [psrs_pkg::PAGE_BITS:0] PAGE_LIMIT =
        (psrs_pkg::PAGE_BITS + 1)'(psrs_pkg::NUM_PAGES);

    logic [psrs_pkg::PAGE_BITS-1:0] r_page,    n_page;
    logic [psrs_pkg::PEND_W-1:0]    r_pending, n_pending;
    logic [psrs_pkg::VALUE_W-1:0]   r_gather,  n_gather;
    logic [psrs_pkg::ADDR_W-1:0]    r_wr_addr, n_wr_addr;
    logic [psrs_pkg::PEND_W-1:0]    pos;
    logic [psrs_pkg::PAGE_BITS-1:0] low;
    t_top                           top;

    assign low = i_rx_byte[psrs_pkg::PAGE_BITS-1:0];
    assign top = t_top'(i_rx_byte[7:6]);
    assign pos = psrs_pkg::PEND_W'(psrs_pkg::REG_BYTES) - r_pending;

    always_comb begin
        n_page    = r_page;
        n_pending = r_pending;
        n_gather  = r_gather;
        n_wr_addr = r_wr_addr;
        o_push    = 1'b0;
        o_word    = '{cmd: psrs_pkg::CMD_INSTR, addr: '0, data: '0, code: low};
        if (i_accept) begin
            if (r_pending != '0) begin
                // every byte is data while a write is open
                case (pos)
                    0:       n_gather[7:0]   = r_gather[7:0]   | i_rx_byte;
                    1:       n_gather[15:8]  = r_gather[15:8]  | i_rx_byte;
                    2:       n_gather[23:16] = r_gather[23:16] | i_rx_byte;
                    default: n_gather = r_gather;
                endcase
                n_pending = r_pending - 1'b1;
                if (r_pending == psrs_pkg::PEND_W'(1)) begin
                    o_push = 1'b1;
                    o_word = '{cmd: psrs_pkg::CMD_WRITE, addr: r_wr_addr,
                               data: n_gather, code: '0};
                end
            end else begin
                unique case (top)
                    TOP_PAGE: begin
                        if ({1'b0, low} < PAGE_LIMIT) begin
                            n_page = low;
                        end
                    end
                    TOP_READ: begin
                        o_push = 1'b1;
                        o_word = '{cmd: psrs_pkg::CMD_READ, addr: {r_page, low},
                                   data: '0, code: '0};
                    end
                    TOP_WRITE: begin
                        n_wr_addr = {r_page, low};
                        n_gather  = '0;
                        n_pending = psrs_pkg::PEND_W'(psrs_pkg::REG_BYTES);
                    end
                    TOP_INSTR: begin
                        o_push = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page    <= '0;
            r_pending <= '0;
            r_gather  <= '0;
            r_wr_addr <= '0;
        end else begin
            r_page    <= n_page;
            r_pending <= n_pending;
            r_gather  <= n_gather;
            r_wr_addr <= n_wr_addr;
        end
    end

endmodule

[rtl/psrs_fifo.sv]
// Short command queue between front and back of the paged serial register slave.
// Uses psrs_pkg for the word type and depth.
module psrs_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  psrs_pkg::t_cmd_word i_word,
    input  logic                i_pop,
    output psrs_pkg::t_cmd_word o_head,
    output logic                o_full,
    output logic                o_empty
);

    localparam logic [psrs_pkg::FIFO_PW-1:0] LAST_PTR =
        psrs_pkg::FIFO_PW'(psrs_pkg::FIFO_DEPTH - 1);

    psrs_pkg::t_cmd_word            r_mem [psrs_pkg::FIFO_DEPTH];
    logic [psrs_pkg::FIFO_PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [psrs_pkg::FIFO_CW-1:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == psrs_pkg::FIFO_CW'(psrs_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/psrs_back.sv]
// Back end of the paged serial register slave: register store, clearing pass after reset,
// and execution of queued words into result strobes. Uses psrs_pkg.
module psrs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [psrs_pkg::ADDR_W-1:0] i_status_addr,
    input  psrs_pkg::t_cmd_word         i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_clearing,
    output psrs_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    localparam logic [psrs_pkg::MEM_AW-1:0] LAST_ENTRY =
        psrs_pkg::MEM_AW'(psrs_pkg::STORE_DEPTH - 1);
    localparam logic [psrs_pkg::IDX_W-1:0] LAST_IDX =
        psrs_pkg::IDX_W'(psrs_pkg::REG_BYTES - 1);

    logic [psrs_pkg::VALUE_W-1:0] r_store [psrs_pkg::STORE_DEPTH];
    logic [psrs_pkg::VALUE_W-1:0] r_rd_data;

    t_state                       r_state;
    logic [psrs_pkg::MEM_AW-1:0]  r_clr_idx;
    logic [psrs_pkg::IDX_W-1:0]   r_idx;
    psrs_pkg::t_cmd_word          r_cmd;
    psrs_pkg::t_result            r_res;

    logic                         mem_we;
    logic [psrs_pkg::MEM_AW-1:0]  mem_waddr;
    logic [psrs_pkg::VALUE_W-1:0] mem_wdata;
    logic [psrs_pkg::VALUE_W-1:0] new_value;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_result   = r_res;

    // write one to clear on the status register, plain store elsewhere
    assign new_value = (r_cmd.addr == i_status_addr) ? (r_rd_data & ~r_cmd.data)
                                                     : r_cmd.data;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = r_cmd.addr[psrs_pkg::MEM_AW-1:0];
            mem_wdata = new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd_data <= r_store[i_head.addr[psrs_pkg::MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_idx      <= '0;
            r_cmd      <= '{cmd: psrs_pkg::CMD_INSTR, addr: '0, data: '0, code: '0};
            r_res      <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_res.strobe <= 1'b0;
                    r_clr_idx    <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_ENTRY) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        r_idx <= '0;
                        unique case (i_head.cmd)
                            psrs_pkg::CMD_READ: begin
                                r_res.strobe <= 1'b0;
                                r_state      <= S_READ;
                            end
                            psrs_pkg::CMD_WRITE: begin
                                r_res.strobe <= 1'b0;
                                r_state      <= S_WRITE;
                            end
                            psrs_pkg::CMD_INSTR: begin
                                r_res <= '{strobe: 1'b1, kind: psrs_pkg::KIND_INSTR,
                                           tx_byte: '0, last: 1'b1, reg_address: '0,
                                           reg_value: '0, instr_code: i_head.code};
                            end
                            default: begin
                                r_res.strobe <= 1'b0;
                                r_state      <= S_IDLE;
                            end
                        endcase
                    end else begin
                        r_res.strobe <= 1'b0;
                    end
                end
                S_READ: begin
                    r_res <= '{strobe: 1'b1, kind: psrs_pkg::KIND_READ,
                               tx_byte: psrs_pkg::byte_of(r_rd_data, r_idx),
                               last: (r_idx == LAST_IDX), reg_address: r_cmd.addr,
                               reg_value: r_rd_data, instr_code: '0};
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_WRITE: begin
                    r_res <= '{strobe: 1'b1, kind: psrs_pkg::KIND_WRITE,
                               tx_byte: '0, last: 1'b1, reg_address: r_cmd.addr,
                               reg_value: new_value, instr_code: '0};
                    r_state <= S_IDLE;
                end
                default: begin
                    r_res.strobe <= 1'b0;
                    r_state      <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/paged_serial_register_slave_unit.sv]
// Top level of the paged serial register slave: configuration register, front end,
// command queue and back end. Depends on psrs_pkg, psrs_front, psrs_fifo and psrs_back.
//
// Usage: present one received byte on i_rx_byte with i_start high; the word is taken at
// any clock edge where o_busy is low. Bytes 10pppppp select page p (pages at or above the
// page count are ignored), 00oooooo read register page*64+o, 01oooooo open a write to it
// and the next three bytes are its data, least significant first, whatever their top
// bits; 11cccccc issue instruction c. Each result appears on the o_ ports for exactly one
// cycle with o_strobe high and cannot be held off, so capture it on that cycle. A read
// yields three strobes (one data byte each, the last flagged), a completed write one
// strobe carrying the value now stored, an instruction one strobe. Writing the status
// register (address set through i_cfg_we / i_cfg_wdata, reset 23) clears the bits that
// are one in the data. Complete words are queued in a two-entry queue; the back end
// handles an instruction as it pops it, a read as a store lookup then one byte per cycle,
// and a write as a lookup then a store. o_busy rises only while that queue is full, and
// after reset while the back end sweeps all 4096 entries of the register store to zero.
// Write the configuration only while the block is idle.
module paged_serial_register_slave_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_rx_byte,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [11:0] o_reg_address,
    output logic [23:0] o_reg_value,
    output logic [5:0]  o_instr_code
);

    logic [psrs_pkg::ADDR_W-1:0] r_status_addr;
    logic                        accept;
    logic                        push;
    logic                        pop;
    logic                        full;
    logic                        empty;
    logic                        clearing;
    psrs_pkg::t_cmd_word         push_word;
    psrs_pkg::t_cmd_word         head_word;
    psrs_pkg::t_result           result;

    // hold off new words while the queue is full or the store is being swept
    assign o_busy = full || clearing;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_addr <= 12'd23;
        end else if (i_cfg_we) begin
            r_status_addr <= i_cfg_wdata;
        end
    end

    psrs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_word    (push_word)
    );

    psrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_head  (head_word),
        .o_full  (full),
        .o_empty (empty)
    );

    psrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status_addr (r_status_addr),
        .i_head        (head_word),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_result      (result)
    );

    // drive the result ports straight from the back end's output register
    assign o_strobe      = result.strobe;
    assign o_kind        = result.kind;
    assign o_tx_byte     = result.tx_byte;
    assign o_last        = result.last;
    assign o_reg_address = result.reg_address;
    assign o_reg_value   = result.reg_value;
    assign o_instr_code  = result.instr_code;

endmodule
